// ===== rtl/tdt_pkg.sv =====
// ----------------------------------------------------------------------------
// tdt_pkg
// Shared sizes, codes and cell control types of the tile deduplication table.
// ----------------------------------------------------------------------------
`default_nettype none

package tdt_pkg;

  localparam int MAX_TILES  = 256;
  localparam int TILE_W     = 64;
  localparam int SLOT_W     = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int CNT_W      = $clog2(MAX_TILES + 1);
  localparam int LIMIT_W    = 9;
  localparam int CMP_W      = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int IDX_EXT_W  = (SLOT_W > 8) ? SLOT_W : 8;
  localparam int GRP_SIZE   = 16;
  localparam int GRP_LOC_W  = 4;
  localparam int NUM_GROUPS = (MAX_TILES + GRP_SIZE - 1) / GRP_SIZE;
  localparam int GRP_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

  localparam logic [1:0] ACT_ADD  = 2'd0;
  localparam logic [1:0] ACT_FIND = 2'd1;
  localparam logic [1:0] ACT_LOAD = 2'd2;

  localparam logic [2:0] ST_MATCH    = 3'd0;
  localparam logic [2:0] ST_NEW      = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_LOADOVF  = 3'd4;

  typedef struct packed {
    logic              en;
    logic [TILE_W-1:0] word;
  } cell_cmp_t;

  typedef struct packed {
    logic              en;
    logic              key_valid;
    logic [TILE_W-1:0] word;
  } cell_wr_t;

endpackage

`default_nettype wire

// ===== rtl/tdt_cell.sv =====
// ----------------------------------------------------------------------------
// tdt_cell
// One table slot: stored tile, key-valid bit and a registered match flag.
// ----------------------------------------------------------------------------
`default_nettype none

module tdt_cell (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire tdt_pkg::cell_cmp_t     cmp,
  input  wire                         cmp_excl,
  input  wire tdt_pkg::cell_wr_t      wr,
  input  wire                         wr_sel,
  output logic                        match_r
);

  logic [tdt_pkg::TILE_W-1:0] tile_r;
  logic                       valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr.en && wr_sel) begin
      valid_r <= wr.key_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr_sel) begin
      tile_r <= wr.word;
    end
    if (cmp.en) begin
      match_r <= valid_r && !cmp_excl && (tile_r == cmp.word);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tdt_prio16.sv =====
// ----------------------------------------------------------------------------
// tdt_prio16
// Registered lowest-set-bit pick over one group of sixteen match flags.
// ----------------------------------------------------------------------------
`default_nettype none

module tdt_prio16 (
  input  wire                                 clk,
  input  wire                                 en,
  input  wire [tdt_pkg::GRP_SIZE-1:0]         match,
  output logic                                hit_r,
  output logic [tdt_pkg::GRP_LOC_W-1:0]       loc_r
);

  logic                          hit_c;
  logic [tdt_pkg::GRP_LOC_W-1:0] loc_c;

  always_comb begin
    hit_c = 1'b0;
    loc_c = '0;
    for (int k = tdt_pkg::GRP_SIZE - 1; k >= 0; k--) begin
      if (match[k]) begin
        hit_c = 1'b1;
        loc_c = tdt_pkg::GRP_LOC_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= hit_c;
      loc_r <= loc_c;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tile_dedup_table.sv =====
// ----------------------------------------------------------------------------
// tile_dedup_table
// Deduplicating character-set table for 8x8 one-bit tiles.
//
// Input channel (in_valid/in_ready) takes an action and a 64-bit tile; the
// result channel (out_valid/out_ready) returns slot index, status and count,
// one beat per input beat, in order. cfg_wr_en/cfg_wr_data write the tile
// limit at once; write it only while the table is idle.
// On accept the tile is compared against every slot in parallel; in S_GRP
// the lowest hit inside each group of sixteen slots is registered; in S_FIN
// the pick across groups is made, the slot is updated and the output
// register is loaded. This compare, group pick and commit sequence runs
// to its end before the next item is accepted.
// The output register holds a finished beat while the receiver stalls; a
// pending commit waits for it to drain, and in_ready stays low meanwhile.
// Reset clears all key-valid bits, the count, the load position and the
// zero-tile flag, and sets the limit to 256; the table is ready at once.
// ----------------------------------------------------------------------------
`default_nettype none

module tile_dedup_table (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               cfg_wr_en,
  input  wire [tdt_pkg::LIMIT_W-1:0]        cfg_wr_data,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire [1:0]                         in_action,
  input  wire [tdt_pkg::TILE_W-1:0]         in_tile_word,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [7:0]                        out_index,
  output logic [2:0]                        out_status,
  output logic [8:0]                        out_tile_count
);

  typedef enum logic [1:0] {S_IDLE, S_GRP, S_FIN} state_t;

  state_t                           state_r;
  logic [1:0]                       act_r;
  logic [tdt_pkg::TILE_W-1:0]       word_r;
  logic [tdt_pkg::CNT_W-1:0]        used_r;
  logic [tdt_pkg::CNT_W-1:0]        load_pos_r;
  logic                             seen_empty_r;
  logic [tdt_pkg::LIMIT_W-1:0]      char_limit_r;
  logic                             out_valid_r;
  logic [7:0]                       out_index_r;
  logic [2:0]                       out_status_r;
  logic [8:0]                       out_count_r;

  logic                             accept;
  logic                             commit;
  tdt_pkg::cell_cmp_t               cmp;
  tdt_pkg::cell_wr_t                wr;
  logic [tdt_pkg::SLOT_W-1:0]       wr_slot;
  logic [tdt_pkg::NUM_GROUPS*tdt_pkg::GRP_SIZE-1:0] match_all;
  logic [tdt_pkg::NUM_GROUPS-1:0]   grp_hit;
  logic [tdt_pkg::GRP_LOC_W-1:0]    grp_loc [tdt_pkg::NUM_GROUPS];

  logic                             pick_any;
  logic [tdt_pkg::GRP_W-1:0]        pick_grp;
  logic [tdt_pkg::GRP_LOC_W-1:0]    pick_loc;
  logic [tdt_pkg::SLOT_W-1:0]       hit_slot;
  logic                             load_ovf;
  logic                             set_full;
  logic                             counted;
  logic                             wr_do;
  logic                             wr_key_valid;
  logic [tdt_pkg::SLOT_W-1:0]       res_slot;
  logic [tdt_pkg::IDX_EXT_W-1:0]    res_slot_ext;
  logic [2:0]                       res_status;
  logic [tdt_pkg::CNT_W-1:0]        used_nxt;
  logic [tdt_pkg::CMP_W-1:0]        used_nxt_ext;
  logic [tdt_pkg::CNT_W-1:0]        load_pos_nxt;
  logic                             seen_empty_nxt;

  assign in_ready       = (state_r == S_IDLE);
  assign accept         = in_valid && in_ready;
  assign commit         = (state_r == S_FIN) && (!out_valid_r || out_ready);
  assign out_valid      = out_valid_r;
  assign out_index      = out_index_r;
  assign out_status     = out_status_r;
  assign out_tile_count = out_count_r;

  assign cmp.en   = accept;
  assign cmp.word = in_tile_word;

  assign wr.en        = commit && wr_do;
  assign wr.key_valid = wr_key_valid;
  assign wr.word      = word_r;

  for (genvar i = 0; i < tdt_pkg::NUM_GROUPS * tdt_pkg::GRP_SIZE; i++) begin : g_slot
    if (i < tdt_pkg::MAX_TILES) begin : g_cell
      logic excl;
      assign excl = (in_action == tdt_pkg::ACT_LOAD) &&
                    (load_pos_r == tdt_pkg::CNT_W'(i));
      tdt_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmp      (cmp),
        .cmp_excl (excl),
        .wr       (wr),
        .wr_sel   (wr_slot == tdt_pkg::SLOT_W'(i)),
        .match_r  (match_all[i])
      );
    end else begin : g_pad
      assign match_all[i] = 1'b0;
    end
  end

  for (genvar g = 0; g < tdt_pkg::NUM_GROUPS; g++) begin : g_grp
    tdt_prio16 u_prio (
      .clk   (clk),
      .en    (state_r == S_GRP),
      .match (match_all[g*tdt_pkg::GRP_SIZE +: tdt_pkg::GRP_SIZE]),
      .hit_r (grp_hit[g]),
      .loc_r (grp_loc[g])
    );
  end

  always_comb begin
    pick_any = 1'b0;
    pick_grp = '0;
    pick_loc = '0;
    for (int g = tdt_pkg::NUM_GROUPS - 1; g >= 0; g--) begin
      if (grp_hit[g]) begin
        pick_any = 1'b1;
        pick_grp = tdt_pkg::GRP_W'(g);
        pick_loc = grp_loc[g];
      end
    end
  end

  assign hit_slot = tdt_pkg::SLOT_W'({pick_grp, pick_loc});

  assign load_ovf = (tdt_pkg::CMP_W'(load_pos_r) >= tdt_pkg::CMP_W'(char_limit_r)) ||
                    (load_pos_r >= tdt_pkg::CNT_W'(tdt_pkg::MAX_TILES));
  assign set_full = (tdt_pkg::CMP_W'(used_r) >= tdt_pkg::CMP_W'(char_limit_r)) ||
                    (used_r >= tdt_pkg::CNT_W'(tdt_pkg::MAX_TILES));
  assign counted  = (word_r != '0) || !seen_empty_r;

  always_comb begin
    wr_do          = 1'b0;
    wr_key_valid   = 1'b0;
    wr_slot        = '0;
    res_slot       = '0;
    res_status     = tdt_pkg::ST_NOTFOUND;
    used_nxt       = used_r;
    load_pos_nxt   = load_pos_r;
    seen_empty_nxt = seen_empty_r;
    if (act_r == tdt_pkg::ACT_LOAD) begin
      if (load_ovf) begin
        res_status = tdt_pkg::ST_LOADOVF;
      end else begin
        wr_do        = 1'b1;
        wr_slot      = load_pos_r[tdt_pkg::SLOT_W-1:0];
        wr_key_valid = counted && !pick_any;
        if (counted) begin
          used_nxt = load_pos_r + 1'b1;
          if (word_r == '0) begin
            seen_empty_nxt = 1'b1;
          end
        end
        load_pos_nxt = load_pos_r + 1'b1;
        res_slot     = load_pos_r[tdt_pkg::SLOT_W-1:0];
        res_status   = tdt_pkg::ST_NEW;
      end
    end else if (pick_any) begin
      res_slot   = hit_slot;
      res_status = tdt_pkg::ST_MATCH;
    end else if (act_r != tdt_pkg::ACT_ADD) begin
      res_status = tdt_pkg::ST_NOTFOUND;
    end else if (set_full) begin
      res_status = tdt_pkg::ST_FULL;
    end else begin
      wr_do        = 1'b1;
      wr_slot      = used_r[tdt_pkg::SLOT_W-1:0];
      wr_key_valid = 1'b1;
      used_nxt     = used_r + 1'b1;
      res_slot     = used_r[tdt_pkg::SLOT_W-1:0];
      res_status   = tdt_pkg::ST_NEW;
    end
  end

  assign res_slot_ext = tdt_pkg::IDX_EXT_W'(res_slot);
  assign used_nxt_ext = tdt_pkg::CMP_W'(used_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      used_r       <= '0;
      load_pos_r   <= '0;
      seen_empty_r <= 1'b0;
      char_limit_r <= tdt_pkg::LIMIT_W'(256);
    end else begin
      if (cfg_wr_en) begin
        char_limit_r <= cfg_wr_data;
      end
      if (accept) begin
        act_r <= in_action;
        word_r <= in_tile_word;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_GRP;
          end
        end
        S_GRP: begin
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (commit) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (commit) begin
        out_valid_r  <= 1'b1;
        out_index_r  <= res_slot_ext[7:0];
        out_status_r <= res_status;
        out_count_r  <= used_nxt_ext[8:0];
        used_r       <= used_nxt;
        load_pos_r   <= load_pos_nxt;
        seen_empty_r <= seen_empty_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= tdt_pkg::CNT_W'(tdt_pkg::MAX_TILES) &&
    load_pos_r <= tdt_pkg::CNT_W'(tdt_pkg::MAX_TILES))
    else $error("count or load position beyond table size");

  a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_GRP) ##1 (state_r == S_FIN))
    else $error("item did not advance through group pick");

  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) && !commit |=> (state_r == S_FIN) && out_valid_r)
    else $error("stalled commit lost");

  a_err_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == tdt_pkg::ST_NOTFOUND ||
                    out_status_r == tdt_pkg::ST_FULL ||
                    out_status_r == tdt_pkg::ST_LOADOVF) |-> out_index_r == 8'd0)
    else $error("error beat carries nonzero index");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the tile deduplication table.
//
// A driver feeds add, find and preload beats from a queue in random bursts,
// and the result side stalls in changing patterns. Every accepted beat runs
// through a local copy of the table to predict slot, status and count. Each
// result beat is checked against the oldest prediction. The tile limit is
// changed between phases while the table is idle. A short directed opening
// covers the zero limit, a second zero tile, repeated preloads, a preload
// that lowers the count, adds over preloaded slots and selector three.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ACT_FIND_ALT = 2'd3;
  localparam int POOL_SIZE = 24;

  typedef struct packed {
    logic [1:0]                 action;
    logic [tdt_pkg::TILE_W-1:0] word;
  } tile_beat_t;

  typedef struct packed {
    logic [7:0] slot;
    logic [2:0] status;
    logic [8:0] tile_count;
  } tile_result_t;

  logic                         clk;
  logic                         rst_n = 1'b0;
  logic                         cfg_wr_en = 1'b0;
  logic [tdt_pkg::LIMIT_W-1:0]  cfg_wr_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [1:0]                   in_action = tdt_pkg::ACT_ADD;
  logic [tdt_pkg::TILE_W-1:0]   in_tile_word = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [7:0]                   out_index;
  logic [2:0]                   out_status;
  logic [8:0]                   out_tile_count;

  tile_dedup_table dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_tile_word   (in_tile_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_index      (out_index),
    .out_status     (out_status),
    .out_tile_count (out_tile_count)
  );

  // table copy
  logic [tdt_pkg::TILE_W-1:0] tile_store [tdt_pkg::MAX_TILES];
  bit                         key_valid [tdt_pkg::MAX_TILES];
  int                         used_count = 0;
  int                         load_pos = 0;
  bit                         seen_zero = 1'b0;
  int                         char_limit = 256;

  tile_beat_t                 tile_beats_q [$];
  tile_result_t               tile_results_q [$];
  logic [tdt_pkg::TILE_W-1:0] tile_pool [POOL_SIZE];
  int                         items_queued = 0;
  int                         beats_in = 0;
  int                         mismatches = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int lowest_hit(logic [tdt_pkg::TILE_W-1:0] word);
    for (int j = 0; j < tdt_pkg::MAX_TILES; j++) begin
      if (key_valid[j] && tile_store[j] == word) return j;
    end
    return -1;
  endfunction

  function automatic tile_result_t apply_tile_action(logic [1:0] act,
                                                     logic [tdt_pkg::TILE_W-1:0] word);
    tile_result_t r;
    int           lim;
    int           pos;
    int           hit;
    lim = (char_limit < tdt_pkg::MAX_TILES) ? char_limit : tdt_pkg::MAX_TILES;
    r.slot = '0;
    if (act == tdt_pkg::ACT_LOAD) begin
      pos = load_pos;
      if (pos >= lim) begin
        r.status = tdt_pkg::ST_LOADOVF;
      end else begin
        key_valid[pos] = 1'b0;
        hit = lowest_hit(word);
        if (word != '0 || !seen_zero) begin
          if (hit < 0) key_valid[pos] = 1'b1;
          used_count = pos + 1;
          if (word == '0) seen_zero = 1'b1;
        end
        tile_store[pos] = word;
        load_pos = pos + 1;
        r.slot = 8'(pos);
        r.status = tdt_pkg::ST_NEW;
      end
    end else begin
      hit = lowest_hit(word);
      if (hit >= 0) begin
        r.slot = 8'(hit);
        r.status = tdt_pkg::ST_MATCH;
      end else if (act != tdt_pkg::ACT_ADD) begin
        r.status = tdt_pkg::ST_NOTFOUND;
      end else if (used_count >= lim) begin
        r.status = tdt_pkg::ST_FULL;
      end else begin
        tile_store[used_count] = word;
        key_valid[used_count] = 1'b1;
        r.slot = 8'(used_count);
        used_count = used_count + 1;
        r.status = tdt_pkg::ST_NEW;
      end
    end
    r.tile_count = 9'(used_count);
    return r;
  endfunction

  // input side and result check
  always @(posedge clk) begin
    tile_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (tile_results_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t unexpected result beat: slot %0d status %0d count %0d",
                     $time, out_index, out_status, out_tile_count);
        end else begin
          want = tile_results_q.pop_front();
          if (out_index !== want.slot || out_status !== want.status ||
              out_tile_count !== want.tile_count) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t result mismatch: expected slot %0d status %0d count %0d,",
                        " got slot %0d status %0d count %0d"},
                       $time, want.slot, want.status, want.tile_count,
                       out_index, out_status, out_tile_count);
          end
        end
      end
      if (in_valid && in_ready) begin
        tile_results_q.push_back(apply_tile_action(in_action, in_tile_word));
        beats_in <= beats_in + 1;
      end
    end
  end

  // driver: bursts with random gaps
  int         beats_offered = 0;
  int         burst_left = 8;
  int         gap_left = 0;
  tile_beat_t next_beat;

  always @(negedge clk) begin
    if (rst_n && !(in_valid && beats_in != beats_offered)) begin
      if (gap_left > 0 || tile_beats_q.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        next_beat = tile_beats_q.pop_front();
        in_valid <= 1'b1;
        in_action <= next_beat.action;
        in_tile_word <= next_beat.word;
        beats_offered++;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // receiver: stall pattern drawn at random from four modes
  int stall_mode = 0;
  int stall_tick = 0;

  always @(negedge clk) begin
    stall_tick++;
    if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (stall_tick % 5) != 0;
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic queue_beat(logic [1:0] act, logic [tdt_pkg::TILE_W-1:0] word);
    tile_beats_q.push_back('{action: act, word: word});
    items_queued++;
  endtask

  task automatic wait_idle();
    while (beats_in != items_queued || tile_results_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(int value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= tdt_pkg::LIMIT_W'(value);
    char_limit = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [tdt_pkg::TILE_W-1:0] pick_tile(int known_pct);
    int                         r;
    logic [tdt_pkg::TILE_W-1:0] w;
    r = $urandom_range(0, 99);
    if (r < 6) return '0;
    if (r < 9) return '1;
    if (r < 9 + known_pct) return tile_pool[$urandom_range(0, POOL_SIZE - 1)];
    w = {$urandom, $urandom};
    if ($urandom_range(0, 2) == 0) tile_pool[$urandom_range(0, POOL_SIZE - 1)] = w;
    return w;
  endfunction

  task automatic queue_random_run(int n);
    int left;
    int run;
    int kind;
    left = n;
    while (left > 0) begin
      kind = $urandom_range(0, 99);
      run = $urandom_range(1, 10);
      if (run > left) run = left;
      for (int k = 0; k < run; k++) begin
        if (kind < 45)
          queue_beat(tdt_pkg::ACT_ADD, pick_tile(45));
        else if (kind < 65)
          queue_beat(tdt_pkg::ACT_LOAD, pick_tile(30));
        else if (kind < 85)
          queue_beat(($urandom_range(0, 3) == 0) ? ACT_FIND_ALT : tdt_pkg::ACT_FIND,
                     pick_tile(60));
        else
          queue_beat(2'($urandom_range(0, 3)), pick_tile(20));
      end
      left -= run;
    end
  endtask

  initial begin
    logic [tdt_pkg::TILE_W-1:0] tile_a;
    int                         lim;
    for (int k = 0; k < POOL_SIZE; k++) tile_pool[k] = {$urandom, $urandom};
    tile_a = {$urandom, $urandom} | 64'h8000_0000_0000_0001;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // zero limit: nothing fits
    write_limit(0);
    queue_beat(tdt_pkg::ACT_ADD, tile_a);
    queue_beat(tdt_pkg::ACT_FIND, tile_a);
    queue_beat(tdt_pkg::ACT_LOAD, '0);
    queue_beat(ACT_FIND_ALT, tile_a);
    queue_beat(tdt_pkg::ACT_ADD, '0);
    wait_idle();

    write_limit(256);
    queue_beat(tdt_pkg::ACT_LOAD, '0);
    queue_beat(tdt_pkg::ACT_LOAD, '0);
    queue_beat(tdt_pkg::ACT_ADD, '1);
    queue_beat(tdt_pkg::ACT_LOAD, '1);
    queue_beat(tdt_pkg::ACT_LOAD, 64'h0123_4567_89AB_CDEF);
    queue_beat(tdt_pkg::ACT_ADD, tile_a);
    queue_beat(tdt_pkg::ACT_ADD, 64'h00FF_00FF_00FF_00FF);
    queue_beat(tdt_pkg::ACT_LOAD, 64'h0F0F_0F0F_F0F0_F0F0);
    queue_beat(tdt_pkg::ACT_FIND, tile_a);
    queue_beat(tdt_pkg::ACT_FIND, 64'h00FF_00FF_00FF_00FF);
    queue_beat(tdt_pkg::ACT_ADD, '0);
    queue_beat(ACT_FIND_ALT, '1);
    queue_beat(tdt_pkg::ACT_ADD, 64'hAAAA_AAAA_AAAA_AAAA);
    queue_beat(tdt_pkg::ACT_FIND, 64'h00FF_00FF_00FF_00FF);
    queue_beat(tdt_pkg::ACT_ADD, 64'h5555_5555_5555_5555);
    wait_idle();

    write_limit(1);
    queue_beat(tdt_pkg::ACT_ADD, 64'h1234_0000_0000_4321);
    queue_beat(tdt_pkg::ACT_LOAD, 64'hFEDC_BA98_7654_3210);
    queue_beat(tdt_pkg::ACT_ADD, '1);
    wait_idle();

    write_limit(511);
    queue_beat(tdt_pkg::ACT_ADD, 64'h8000_0000_0000_0001);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 5))
        0: lim = used_count + $urandom_range(0, 24);
        1: lim = load_pos + $urandom_range(0, 30);
        2: lim = 1;
        3: lim = 511;
        4: lim = 256;
        default: lim = $urandom_range(1, 256);
      endcase
      if (lim > 511) lim = 511;
      write_limit(lim);
      queue_random_run(144);
      wait_idle();
    end

    repeat (10) @(negedge clk);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
